// ----- rtl/mcpg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint circle generator package
// Item kinds, pixel sequencing constants and decision-variable constants
// shared by the interfaces and the generator modules.
// ----------------------------------------------------------------------------
package mcpg_pkg;

  // What an input beat asks for.
  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } kind_t;

  // Eight symmetric pixels per octant point.
  localparam int PIX_PER_STEP = 8;
  localparam int PIX_IDX_BITS = $clog2(PIX_PER_STEP);

  typedef logic [PIX_IDX_BITS-1:0] pix_idx_t;

  localparam pix_idx_t LAST_PIX = pix_idx_t'(PIX_PER_STEP - 1);

  // Decision variable: d0 = 3 - 2r, then +4(x-y)+10 on a diagonal move,
  // +4x+6 on an axial move.
  localparam int DEC_INIT      = 3;
  localparam int DEC_DIAG_BIAS = 10;
  localparam int DEC_AXIS_BIAS = 6;
  localparam int DEC_SHIFT     = 2;

  // Extra decision bits over the coordinate width.
  localparam int DEC_EXTRA_BITS = 4;
  // Extra pixel bits over the coordinate width (sign and carry).
  localparam int PIX_EXTRA_BITS = 2;

endpackage

// ----- rtl/mcpg_item_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle command channel
// Valid/ready channel carrying start and step commands.
// ----------------------------------------------------------------------------
interface mcpg_item_if #(
  parameter int COORD_BITS = 12
);
  logic                    valid;
  logic                    ready;
  mcpg_pkg::kind_t         kind;
  logic [COORD_BITS-1:0]   center_x;
  logic [COORD_BITS-1:0]   center_y;
  logic [COORD_BITS-2:0]   radius;

  modport source (output valid, kind, center_x, center_y, radius, input ready);
  modport sink   (input valid, kind, center_x, center_y, radius, output ready);
endinterface

// ----- rtl/mcpg_pixel_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel carrying one plotted pixel per beat.
// ----------------------------------------------------------------------------
interface mcpg_pixel_if #(
  parameter int COORD_BITS = 12
);
  logic                                                 valid;
  logic                                                 ready;
  logic signed [COORD_BITS+mcpg_pkg::PIX_EXTRA_BITS-1:0] pixel_x;
  logic signed [COORD_BITS+mcpg_pkg::PIX_EXTRA_BITS-1:0] pixel_y;
  logic                                                 last_of_step;
  logic                                                 done_res;

  modport source (output valid, pixel_x, pixel_y, last_of_step, done_res, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last_of_step, done_res, output ready);
endinterface

// ----- rtl/midpoint_circle_pixel_generator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint circle pixel generator
// Integer midpoint circle rasterizer emitting eight symmetric pixels per step.
// ----------------------------------------------------------------------------
// Usage:
//   The items channel takes start and step beats. A start beat latches the
//   center and radius and primes the decision variable; it produces nothing.
//   Each step beat while a circle is running produces eight pixel beats on
//   the pixels channel, in octant order, the eighth marked with last_of_step
//   and, when the point has crossed the diagonal, with done_res. A step beat
//   while idle is consumed silently; a start beat while running restarts.
//   The first pixel of a step is valid once its point record has passed the
//   point queue and the registered output stage. Pixels leave at one pixel per
//   cycle while pixels is not stalled, set by the single pixel emitter draining the point queue.
//   The walker updates its point when a step is accepted and parks a point
//   record in a two-entry queue, so it keeps taking beats while the emitter
//   is still working or the receiver stalls; it backs off only when the
//   queue is full. A stall on pixels simply holds the output register.
//   Reset (synchronous, active high) empties the queue and output stage and
//   leaves the generator idle with all point state cleared.
// ----------------------------------------------------------------------------
module midpoint_circle_pixel_generator_unit #(
  parameter int COORD_BITS  = 12,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  mcpg_item_if.sink     items,
  mcpg_pixel_if.source  pixels
);

  // Point record: center x, center y, offset x, offset y, finished flag.
  localparam int REC_BITS = 4 * COORD_BITS + 1;

  logic                push_valid;
  logic                push_ready;
  logic [REC_BITS-1:0] push_data;
  logic                pop_valid;
  logic                pop_ready;
  logic [REC_BITS-1:0] pop_data;

  // Front: command decode, octant point and decision variable update.
  mcpg_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .items      (items),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Queue of pending point records between walker and emitter.
  mcpg_queue #(
    .WIDTH (REC_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back: eight pixels per record through the registered output stage.
  mcpg_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .pixels    (pixels)
  );

endmodule

// ----- rtl/mcpg_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle walker front end
// Accepts commands, holds the octant point and decision variable, and pushes
// one point record per step of a running circle into the queue.
// ----------------------------------------------------------------------------
module mcpg_front #(
  parameter int COORD_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  mcpg_item_if.sink                 items,
  output logic                      push_valid,
  input  logic                      push_ready,
  output logic [4*COORD_BITS:0]     push_data
);

  localparam int DW = COORD_BITS + mcpg_pkg::DEC_EXTRA_BITS;

  logic [COORD_BITS-1:0]  offset_x;
  logic [COORD_BITS-1:0]  offset_y;
  logic signed [DW-1:0]   decision;
  logic [COORD_BITS-1:0]  held_center_x;
  logic [COORD_BITS-1:0]  held_center_y;
  logic                   active;

  logic                   accept;
  logic                   is_step;
  logic                   diag_move;
  logic signed [DW-1:0]   diff;
  logic signed [DW-1:0]   decision_next;
  logic [COORD_BITS-1:0]  x_next;
  logic [COORD_BITS-1:0]  y_next;
  logic                   finished;

  assign items.ready = push_ready;
  assign accept      = items.valid && items.ready;
  assign is_step     = (items.kind == mcpg_pkg::KIND_STEP);

  always_comb begin
    diag_move = (decision > 0);
    diff      = $signed(DW'(offset_x)) - $signed(DW'(offset_y));
    if (diag_move) begin
      decision_next = decision + (diff <<< mcpg_pkg::DEC_SHIFT)
                    + DW'(mcpg_pkg::DEC_DIAG_BIAS);
      y_next        = (offset_y == '0) ? '0 : offset_y - COORD_BITS'(1);
    end else begin
      decision_next = decision + $signed(DW'(offset_x) << mcpg_pkg::DEC_SHIFT)
                    + DW'(mcpg_pkg::DEC_AXIS_BIAS);
      y_next        = offset_y;
    end
    x_next   = offset_x + COORD_BITS'(1);
    // A clamped y of zero still sits below x_next, so the crossing is seen.
    finished = (y_next < x_next);
  end

  assign push_valid = accept && is_step && active;
  assign push_data  = {held_center_x, held_center_y, offset_x, offset_y, finished};

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x      <= '0;
      offset_y      <= '0;
      decision      <= '0;
      held_center_x <= '0;
      held_center_y <= '0;
      active        <= 1'b0;
    end else if (accept) begin
      if (!is_step) begin
        held_center_x <= items.center_x;
        held_center_y <= items.center_y;
        offset_x      <= '0;
        offset_y      <= COORD_BITS'(items.radius);
        decision      <= DW'(mcpg_pkg::DEC_INIT) - DW'({items.radius, 1'b0});
        active        <= 1'b1;
      end else if (active) begin
        offset_x <= x_next;
        offset_y <= y_next;
        decision <= decision_next;
        active   <= !finished;
      end
    end
  end

endmodule

// ----- rtl/mcpg_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point record queue
// Small register FIFO that decouples the walker from the pixel emitter.
// ----------------------------------------------------------------------------
module mcpg_queue #(
  parameter int WIDTH = 49,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ----- rtl/mcpg_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel emitter back end
// Expands each point record into its eight symmetric pixels, one per cycle
// while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module mcpg_back #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  logic [4*COORD_BITS:0] pop_data,
  mcpg_pixel_if.source          pixels
);

  localparam int PW = COORD_BITS + mcpg_pkg::PIX_EXTRA_BITS;

  mcpg_pkg::pix_idx_t     pix_idx;
  logic                   load;
  logic                   take;
  logic                   last_pix;

  logic [COORD_BITS-1:0]  rec_cx;
  logic [COORD_BITS-1:0]  rec_cy;
  logic [COORD_BITS-1:0]  rec_x;
  logic [COORD_BITS-1:0]  rec_y;
  logic                   rec_done;

  logic [PW-1:0]          u;
  logic [PW-1:0]          v;
  logic [PW-1:0]          px;
  logic [PW-1:0]          py;

  assign {rec_cx, rec_cy, rec_x, rec_y, rec_done} = pop_data;

  // Output stage may take a new pixel when empty or being drained.
  assign load      = !pixels.valid || pixels.ready;
  assign take      = load && pop_valid;
  assign last_pix  = (pix_idx == mcpg_pkg::LAST_PIX);
  assign pop_ready = load && last_pix;

  // Index bit 2 swaps the roles of x and y, bit 0 negates the x term,
  // bit 1 negates the y term.
  always_comb begin
    u  = pix_idx[2] ? PW'(rec_y) : PW'(rec_x);
    v  = pix_idx[2] ? PW'(rec_x) : PW'(rec_y);
    px = pix_idx[0] ? PW'(rec_cx) - u : PW'(rec_cx) + u;
    py = pix_idx[1] ? PW'(rec_cy) - v : PW'(rec_cy) + v;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pixels.pixel_x      <= $signed(px);
      pixels.pixel_y      <= $signed(py);
      pixels.last_of_step <= last_pix;
      pixels.done_res     <= last_pix && rec_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixels.valid <= 1'b0;
      pix_idx      <= '0;
    end else if (load) begin
      pixels.valid <= pop_valid;
      if (pop_valid) begin
        pix_idx <= pix_idx + mcpg_pkg::pix_idx_t'(1);
      end
    end
  end

endmodule
